// ===== rtl/core/llfp_pkg.sv =====
// shared types, codes and widths of the linked list free pool manager
package llfp_pkg;

   // default sizes of the pool
   localparam int unsigned DEF_POOL_NODES   = 8;
   localparam int unsigned DEF_PAYLOAD_BITS = 32;

   // fixed field widths on the stream ports
   localparam int unsigned IDX_OUT_BITS      = 4;
   localparam int unsigned PAYLOAD_PORT_BITS = 32;
   localparam int unsigned REQ_TDATA_BITS    = 40;
   localparam int unsigned RSP_TDATA_BITS    = 56;
   localparam int unsigned RSP_PAD_BITS      = 4;

   // operation codes of a request item
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_CREATE = 2'd3
   } op_type;

   // status codes of a result item
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE  = 4'd0,
      S_INS_A = 4'd1,
      S_INS_B = 4'd2,
      S_INS_C = 4'd3,
      S_DEL_H = 4'd4,
      S_DEL_A = 4'd5,
      S_DEL_B = 4'd6,
      S_DEL_C = 4'd7,
      S_RD_A  = 4'd8,
      S_DONE  = 4'd9
   } state_type;

endpackage

// ===== rtl/core/llfp_link_ram.sv =====
// next-link memory of the node pool, one write and one registered read port
module llfp_link_ram #(
   parameter int unsigned POOL_NODES = llfp_pkg::DEF_POOL_NODES,
   parameter int unsigned IDX_BITS   = $clog2(POOL_NODES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  logic [IDX_BITS:0]   wr_link,
   input  logic [IDX_BITS-1:0] rd_addr,
   output logic [IDX_BITS:0]   rd_link
);
   import llfp_pkg::*;

   localparam logic [IDX_BITS:0] NIL_LINK = {1'b1, {IDX_BITS{1'b0}}};

   logic [IDX_BITS:0]     link_mem [POOL_NODES];
   logic [POOL_NODES-1:0] valid_ff;
   logic [IDX_BITS:0]     rd_link_ff;
   logic [IDX_BITS:0]     chain_link;

   // an entry never written links to the next node, the last one to nil
   assign chain_link = (rd_addr == IDX_BITS'(POOL_NODES - 1)) ? NIL_LINK
                                                             : {1'b0, rd_addr + 1'b1};

   // written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_link;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_link_ff <= valid_ff[rd_addr] ? link_mem[rd_addr] : chain_link;
   end

   assign rd_link = rd_link_ff;

endmodule

// ===== rtl/core/llfp_data_ram.sv =====
// payload memory of the node pool, one write and one registered read port
module llfp_data_ram #(
   parameter int unsigned POOL_NODES = llfp_pkg::DEF_POOL_NODES,
   parameter int unsigned IDX_BITS   = $clog2(POOL_NODES),
   parameter int unsigned DATA_BITS  = llfp_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_BITS-1:0]  wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [IDX_BITS-1:0]  rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   import llfp_pkg::*;

   logic [DATA_BITS-1:0]  data_mem [POOL_NODES];
   logic [POOL_NODES-1:0] valid_ff;
   logic [DATA_BITS-1:0]  rd_data_ff;

   // written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
   end

   // registered read, an entry never written reads all ones
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? data_mem[rd_addr] : '1;
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/linked_list_free_pool_manager.sv =====
// top level: list sequencer, head registers and result register of the pool manager
// sequence: create and early failures go straight to S_DONE; read, insert at head, delete at
//    head and delete with no successor pass S_RD_A, S_INS_A, S_DEL_H or S_DEL_A; insert or
//    delete after a node pass S_INS_A-C or S_DEL_A-C; one item at a time; link port used in turn
// reset: synchronous; list empty, every node chained free, payloads read all ones,
//    done by written flags in the memories, so items are taken right after reset
module linked_list_free_pool_manager #(
   parameter int unsigned POOL_NODES   = llfp_pkg::DEF_POOL_NODES,
   parameter int unsigned PAYLOAD_BITS = llfp_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // operation[1:0], position[5:2], payload[37:6], zero[39:38]
   input  logic [llfp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status[1:0], node_index[5:2], payload_out[37:6], next_index[41:38],
   // head_index[45:42], free_index[49:46], list_empty[50], pool_full[51], zero[55:52]
   output logic [llfp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import llfp_pkg::*;

   localparam int unsigned IDX_BITS   = $clog2(POOL_NODES);
   localparam int unsigned LINK_BITS  = IDX_BITS + 1;
   localparam int unsigned STORE_BITS = (PAYLOAD_BITS < PAYLOAD_PORT_BITS) ? PAYLOAD_BITS
                                                                            : PAYLOAD_PORT_BITS;
   localparam logic [LINK_BITS-1:0] NIL_LINK = {1'b1, {IDX_BITS{1'b0}}};

   // link to port index, nil shows as all ones
   function automatic logic [IDX_OUT_BITS-1:0] idx_out(input logic [LINK_BITS-1:0] lnk);
      idx_out = lnk[IDX_BITS] ? '1 : IDX_OUT_BITS'(lnk[IDX_BITS-1:0]);
   endfunction

   state_type                state_ff, state_in;
   logic [LINK_BITS-1:0]     list_head_ff, list_head_in;
   logic [LINK_BITS-1:0]     free_head_ff, free_head_in;
   logic [IDX_BITS-1:0]      pos_ff, pos_in;
   logic                     nil_ff, nil_in;
   logic [STORE_BITS-1:0]    data_ff, data_in;
   logic [IDX_BITS-1:0]      t_ff, t_in;
   logic [LINK_BITS-1:0]     tmp_ff, tmp_in;
   status_type               res_status_ff, res_status_in;
   logic [LINK_BITS-1:0]     res_node_ff, res_node_in;
   logic [STORE_BITS-1:0]    res_pay_ff, res_pay_in;
   logic [LINK_BITS-1:0]     res_next_ff, res_next_in;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;

   op_type                   req_op;
   logic [3:0]               req_raw;
   logic [PAYLOAD_PORT_BITS-1:0] req_pay;
   logic                     req_nil;
   logic                     req_range;
   logic [IDX_BITS-1:0]      req_pos;

   logic                     link_wr_en;
   logic [IDX_BITS-1:0]      link_wr_addr;
   logic [LINK_BITS-1:0]     link_wr_link;
   logic [IDX_BITS-1:0]      link_rd_addr;
   logic [LINK_BITS-1:0]     link_rd_link;
   logic                     data_wr_en;
   logic [IDX_BITS-1:0]      data_wr_addr;
   logic [STORE_BITS-1:0]    data_wr_data;
   logic [STORE_BITS-1:0]    data_rd_data;
   logic                     out_load;

   // request field decode
   assign req_op    = op_type'(req_tdata[1:0]);
   assign req_raw   = req_tdata[5:2];
   assign req_pay   = req_tdata[37:6];
   assign req_nil   = (req_raw == 4'hF);
   assign req_range = !req_raw[3] && ({29'd0, req_raw[2:0]} < 32'(POOL_NODES));
   assign req_pos   = IDX_BITS'(req_raw[2:0]);

   // node memories
   llfp_link_ram #(
      .POOL_NODES (POOL_NODES),
      .IDX_BITS   (IDX_BITS)
   ) u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_link (link_wr_link),
      .rd_addr (link_rd_addr),
      .rd_link (link_rd_link)
   );

   llfp_data_ram #(
      .POOL_NODES (POOL_NODES),
      .IDX_BITS   (IDX_BITS),
      .DATA_BITS  (STORE_BITS)
   ) u_data_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_addr (req_pos),
      .rd_data (data_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         list_head_ff  <= NIL_LINK;
         free_head_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         list_head_ff  <= list_head_in;
         free_head_ff  <= free_head_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      nil_ff        <= nil_in;
      data_ff       <= data_in;
      t_ff          <= t_in;
      tmp_ff        <= tmp_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_pay_ff    <= res_pay_in;
      res_next_ff   <= res_next_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   // sequencer: next state, head updates and memory accesses
   always_comb begin
      state_in      = state_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      pos_in        = pos_ff;
      nil_in        = nil_ff;
      data_in       = data_ff;
      t_in          = t_ff;
      tmp_in        = tmp_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_pay_in    = res_pay_ff;
      res_next_in   = res_next_ff;
      req_tready    = 1'b0;
      link_wr_en    = 1'b0;
      link_wr_addr  = t_ff;
      link_wr_link  = free_head_ff;
      link_rd_addr  = pos_ff;
      data_wr_en    = 1'b0;
      data_wr_addr  = t_ff;
      data_wr_data  = '1;
      out_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               pos_in        = req_pos;
               nil_in        = req_nil;
               data_in       = req_pay[STORE_BITS-1:0];
               res_status_in = STAT_OK;
               res_node_in   = NIL_LINK;
               res_pay_in    = '0;
               res_next_in   = NIL_LINK;
               case (req_op)
                  OP_INSERT: begin
                     if (free_head_ff[IDX_BITS]) begin
                        res_status_in = STAT_FULL;
                        state_in      = S_DONE;
                     end else if (!req_nil && !req_range) begin
                        res_status_in = STAT_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        link_rd_addr = free_head_ff[IDX_BITS-1:0];
                        t_in         = free_head_ff[IDX_BITS-1:0];
                        state_in     = S_INS_A;
                     end
                  end
                  OP_DELETE: begin
                     if (list_head_ff[IDX_BITS]) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = S_DONE;
                     end else if (req_nil) begin
                        link_rd_addr = list_head_ff[IDX_BITS-1:0];
                        t_in         = list_head_ff[IDX_BITS-1:0];
                        state_in     = S_DEL_H;
                     end else if (!req_range) begin
                        res_status_in = STAT_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        link_rd_addr = req_pos;
                        state_in     = S_DEL_A;
                     end
                  end
                  OP_READ: begin
                     if (!req_range) begin
                        res_status_in = STAT_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        link_rd_addr = req_pos;
                        state_in     = S_RD_A;
                     end
                  end
                  OP_CREATE: begin
                     list_head_in = NIL_LINK;
                     state_in     = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // insert: link of the taken node is back, store the payload
         S_INS_A: begin
            tmp_in       = link_rd_link;
            res_node_in  = {1'b0, t_ff};
            data_wr_en   = 1'b1;
            data_wr_data = data_ff;
            if (nil_ff) begin
               link_wr_en   = 1'b1;
               link_wr_link = list_head_ff;
               list_head_in = {1'b0, t_ff};
               free_head_in = link_rd_link;
               state_in     = S_DONE;
            end else begin
               link_rd_addr = pos_ff;
               state_in     = S_INS_B;
            end
         end
         // insert: new node takes over the predecessor's link
         S_INS_B: begin
            link_wr_en   = 1'b1;
            link_wr_link = link_rd_link;
            state_in     = S_INS_C;
         end
         // insert: predecessor points to the new node
         S_INS_C: begin
            link_wr_en   = 1'b1;
            link_wr_addr = pos_ff;
            link_wr_link = {1'b0, t_ff};
            free_head_in = tmp_ff;
            state_in     = S_DONE;
         end
         // delete at head: unlink and push onto the free list
         S_DEL_H: begin
            list_head_in = link_rd_link;
            link_wr_en   = 1'b1;
            data_wr_en   = 1'b1;
            free_head_in = {1'b0, t_ff};
            res_node_in  = {1'b0, t_ff};
            state_in     = S_DONE;
         end
         // delete after a node: successor known, fetch its link
         S_DEL_A: begin
            if (link_rd_link[IDX_BITS]) begin
               res_status_in = STAT_BADPOS;
               state_in      = S_DONE;
            end else begin
               t_in         = link_rd_link[IDX_BITS-1:0];
               link_rd_addr = link_rd_link[IDX_BITS-1:0];
               state_in     = S_DEL_B;
            end
         end
         // delete: predecessor skips the removed node
         S_DEL_B: begin
            link_wr_en   = 1'b1;
            link_wr_addr = pos_ff;
            link_wr_link = link_rd_link;
            state_in     = S_DEL_C;
         end
         // delete: removed node goes onto the free list
         S_DEL_C: begin
            link_wr_en   = 1'b1;
            data_wr_en   = 1'b1;
            free_head_in = {1'b0, t_ff};
            res_node_in  = {1'b0, t_ff};
            state_in     = S_DONE;
         end
         // read: both memories answered
         S_RD_A: begin
            res_node_in = {1'b0, pos_ff};
            res_pay_in  = data_rd_data;
            res_next_in = link_rd_link;
            state_in    = S_DONE;
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_BITS{1'b0}},
                          free_head_ff[IDX_BITS],
                          list_head_ff[IDX_BITS],
                          idx_out(free_head_ff),
                          idx_out(list_head_ff),
                          idx_out(res_next_ff),
                          PAYLOAD_PORT_BITS'(res_pay_ff),
                          idx_out(res_node_ff),
                          res_status_ff};
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   // a failed operation never names a node
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != STAT_OK) |-> (rsp_tdata[5:2] == 4'hF))
      else $error("failed operation reports a node");

   // no memory write while waiting for an item
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!link_wr_en && !data_wr_en))
      else $error("memory write while idle");

   // a new result only ever comes out of the hand-off state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_DONE))
      else $error("result shown without hand-off");

endmodule

// ===== bench/tb_top.sv =====
// self-checking stream bench for the linked list free pool manager
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import llfp_pkg::*;

   localparam int unsigned NODES       = DEF_POOL_NODES;
   localparam logic [3:0]  NIL         = 4'hF;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam int          HOLD_CYCLES = 150;

   typedef logic [3:0] node_idx_type;
   typedef node_idx_type node_list_type[$];

   // one result item, lowest field last so it lines up with rsp_tdata
   typedef struct packed {
      logic         full;
      logic         empty;
      node_idx_type free;
      node_idx_type head;
      node_idx_type link;
      logic [31:0]  word;
      node_idx_type node;
      status_type   status;
   } pool_reply_type;

   // shadow copy of the pool, plus the replies it still owes
   class free_pool_shadow;
      node_idx_type   link_mem [NODES];
      logic [31:0]    word_mem [NODES];
      node_idx_type   list_head;
      node_idx_type   free_head;
      pool_reply_type pending_replies[$];
      int             mismatches;

      // state right after reset
      function void clear_pool();
         for (int i = 0; i < NODES; i++) begin
            link_mem[i] = (i + 1 < NODES) ? node_idx_type'(i + 1) : NIL;
            word_mem[i] = ALL_ONES;
         end
         list_head  = NIL;
         free_head  = 4'd0;
         mismatches = 0;
      endfunction

      // walk the list from its head, bounded since links may form loops
      function node_list_type chain_nodes(bit with_successor);
         node_list_type q;
         node_idx_type  n;
         n = list_head;
         for (int i = 0; i < NODES && n != NIL; i++) begin
            if (!with_successor || link_mem[n] != NIL) q.push_back(n);
            n = link_mem[n];
         end
         return q;
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction

      // update the pool for one accepted item and queue its reply
      function void apply_request(op_type op, node_idx_type pos, logic [31:0] data);
         pool_reply_type r;
         node_idx_type   t;
         logic           is_nil;
         logic           in_range;
         is_nil   = (pos == NIL);
         in_range = !pos[3];
         r        = '0;
         r.status = STAT_OK;
         r.node   = NIL;
         r.link   = NIL;
         case (op)
            OP_INSERT: begin
               if (free_head == NIL) begin
                  r.status = STAT_FULL;
               end else if (!is_nil && !in_range) begin
                  r.status = STAT_BADPOS;
               end else begin
                  t           = free_head;
                  free_head   = link_mem[t];
                  word_mem[t] = data;
                  if (is_nil) begin
                     link_mem[t] = list_head;
                     list_head   = t;
                  end else begin
                     link_mem[t]   = link_mem[pos];
                     link_mem[pos] = t;
                  end
                  r.node = t;
               end
            end
            OP_DELETE: begin
               if (list_head == NIL) begin
                  r.status = STAT_EMPTY;
               end else if (is_nil) begin
                  t           = list_head;
                  list_head   = link_mem[t];
                  link_mem[t] = free_head;
                  word_mem[t] = ALL_ONES;
                  free_head   = t;
                  r.node      = t;
               end else if (!in_range || link_mem[pos] == NIL) begin
                  r.status = STAT_BADPOS;
               end else begin
                  t             = link_mem[pos];
                  link_mem[pos] = link_mem[t];
                  link_mem[t]   = free_head;
                  word_mem[t]   = ALL_ONES;
                  free_head     = t;
                  r.node        = t;
               end
            end
            OP_READ: begin
               if (!in_range) begin
                  r.status = STAT_BADPOS;
               end else begin
                  r.node = pos;
                  r.word = word_mem[pos];
                  r.link = link_mem[pos];
               end
            end
            default: begin
               list_head = NIL;
            end
         endcase
         r.head  = list_head;
         r.free  = free_head;
         r.empty = (list_head == NIL);
         r.full  = (free_head == NIL);
         pending_replies.push_back(r);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("tb_top mismatch: %s got %0h want %0h", field, got, want);
      endtask

      // compare one result item with the oldest owed reply
      task compare_result(logic [RSP_TDATA_BITS-1:0] raw);
         pool_reply_type got;
         pool_reply_type want;
         if (pending_replies.size() == 0) begin
            report("result with no item waiting", raw[31:0], 32'd0);
            return;
         end
         got  = pool_reply_type'(raw[$bits(pool_reply_type)-1:0]);
         want = pending_replies.pop_front();
         if (raw[RSP_TDATA_BITS-1 -: RSP_PAD_BITS] !== '0)
            report("pad bits", raw[RSP_TDATA_BITS-1 -: RSP_PAD_BITS], 32'd0);
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.node !== want.node) report("node_index", got.node, want.node);
         if (got.word !== want.word) report("payload_out", got.word, want.word);
         if (got.link !== want.link) report("next_index", got.link, want.link);
         if (got.head !== want.head) report("head_index", got.head, want.head);
         if (got.free !== want.free) report("free_index", got.free, want.free);
         if (got.empty !== want.empty) report("list_empty", got.empty, want.empty);
         if (got.full !== want.full) report("pool_full", got.full, want.full);
      endtask
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;

   free_pool_shadow shadow;
   bit              send_gaps     = 1'b0;
   bit              take_gaps     = 1'b0;
   int              hold_request  = 0;
   int              lossy_creates = 0;

   linked_list_free_pool_manager uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one item until taken, then maybe go quiet for a burst
   task automatic send_item(op_type op, node_idx_type pos, logic [31:0] data);
      req_tdata  <= {2'b00, data, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(op, pos, data);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every owed result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // mostly well-formed list traffic, some raw noise
   task automatic random_item(bit noisy);
      node_list_type chain;
      node_list_type inner;
      op_type        op;
      node_idx_type  pos;
      logic [31:0]   data;
      int            roll;
      bit            create_ok;
      data  = $urandom();
      chain = shadow.chain_nodes(1'b0);
      // a create on a busy list strands its nodes, so keep those rare
      create_ok = (chain.size() == 0) ||
                  (lossy_creates < 3 && chain.size() <= 2 && shadow.free_head != NIL);
      if (noisy) begin
         op  = op_type'($urandom_range(0, 3));
         pos = node_idx_type'($urandom_range(0, 15));
         if (op == OP_CREATE && !create_ok) op = OP_READ;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 20) op = OP_READ;
         else if (roll < 23 && create_ok) op = OP_CREATE;
         else if ($urandom_range(0, NODES) >= chain.size()) op = OP_INSERT;
         else op = OP_DELETE;
         if (op == OP_INSERT && shadow.free_head == NIL && chain.size() != 0)
            op = OP_DELETE;
         case (op)
            OP_INSERT: begin
               if (chain.size() == 0 || $urandom_range(0, 3) == 0) pos = NIL;
               else pos = chain[$urandom_range(0, chain.size() - 1)];
            end
            OP_DELETE: begin
               inner = shadow.chain_nodes(1'b1);
               if (inner.size() == 0 || $urandom_range(0, 3) == 0) pos = NIL;
               else pos = inner[$urandom_range(0, inner.size() - 1)];
            end
            OP_READ: pos = node_idx_type'($urandom_range(0, NODES - 1));
            default: pos = node_idx_type'($urandom_range(0, 15));
         endcase
      end
      if (op == OP_CREATE && chain.size() != 0) lossy_creates++;
      send_item(op, pos, data);
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (take_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // check every result item taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.compare_result(rsp_tdata);
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // stimulus
   initial begin
      node_list_type chain;
      shadow = new();
      shadow.clear_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reads of the reset pool, nil and out of range positions
      send_item(OP_READ, 4'd0, $urandom());
      send_item(OP_READ, 4'd7, $urandom());
      send_item(OP_READ, NIL, $urandom());
      send_item(OP_READ, 4'd8, $urandom());
      send_item(OP_READ, 4'hE, $urandom());
      // delete from an empty list, insert after a bad position
      send_item(OP_DELETE, NIL, $urandom());
      send_item(OP_INSERT, 4'd8, $urandom());
      // create with one node on the list strands that node
      send_item(OP_INSERT, NIL, 32'h0000_0000);
      send_item(OP_CREATE, NIL, $urandom());
      send_item(OP_DELETE, NIL, $urandom());
      // fill the rest of the pool at the head, after nodes and after the tail
      send_item(OP_INSERT, NIL, ALL_ONES);
      send_item(OP_INSERT, 4'd1, 32'hA5A5_5A5A);
      send_item(OP_INSERT, NIL, $urandom());
      chain = shadow.chain_nodes(1'b0);
      send_item(OP_INSERT, chain[$], $urandom());
      send_item(OP_INSERT, 4'd2, $urandom());
      send_item(OP_INSERT, NIL, $urandom());
      send_item(OP_INSERT, 4'd3, $urandom());
      // full pool wins over a bad position
      send_item(OP_INSERT, NIL, $urandom());
      send_item(OP_INSERT, 4'd9, $urandom());
      // delete after the tail, at the head, after the head
      chain = shadow.chain_nodes(1'b0);
      send_item(OP_DELETE, chain[$], $urandom());
      send_item(OP_DELETE, NIL, $urandom());
      send_item(OP_DELETE, shadow.list_head, $urandom());
      send_item(OP_READ, shadow.free_head, $urandom());
      send_item(OP_DELETE, 4'd8, $urandom());
      send_item(OP_READ, 4'd7, $urandom());

      // random traffic, idling switched on and off in stretches
      for (int i = 0; i < 200; i++) begin
         if (i % 40 == 0) begin
            send_gaps = ($urandom_range(0, 2) != 0);
            take_gaps = ($urandom_range(0, 2) != 0);
         end
         random_item($urandom_range(0, 9) == 0);
      end

      // long hold on the result side while items keep coming
      send_gaps    = 1'b0;
      take_gaps    = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 20; i++) random_item(1'b0);

      // sender waits for every result before going on
      wait_drained();
      for (int i = 0; i < 200; i++) begin
         if (i % 40 == 0) begin
            send_gaps = ($urandom_range(0, 2) != 0);
            take_gaps = ($urandom_range(0, 2) != 0);
         end
         random_item($urandom_range(0, 3) == 0);
      end

      // closing stretch at full rate
      send_gaps = 1'b0;
      take_gaps = 1'b0;
      for (int i = 0; i < 80; i++) random_item($urandom_range(0, 9) == 0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
